// ===== rtl/ttw_pkg.sv =====
// Shared types and constants for the text terminal writer.
// No dependencies; imported by the top level.
package ttw_pkg;

    localparam int CELL_W = 16;

    typedef logic [7:0]        t_byte;
    typedef logic [CELL_W-1:0] t_cell;

    typedef enum logic {
        CMD_PUT  = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    localparam t_byte CH_NEWLINE  = 8'h0A;
    localparam t_byte CH_RETURN   = 8'h0D;
    localparam t_byte CH_SPACE    = 8'h20;
    localparam t_byte RESET_COLOR = 8'h07;

    function automatic t_cell make_cell(input t_byte ch, input t_byte color);
        return {color, ch};
    endfunction

endpackage

// ===== rtl/text_terminal_writer.sv =====
// Text terminal writer top level: cursor control, scroll sequencer and screen RAM.
// Depends on ttw_pkg and ttw_ram.
//
// After reset the block sweeps the whole screen to grey spaces, one cell per clock, with busy
// held high until the sweep ends. A put that does not scroll is taken while idle and its
// result appears on the next cycle; a read passes through the registered RAM read and the
// READ state before its result is shown. A put that moves past the last row scrolls: the
// single RAM write port moves one cell per clock, so busy stays high through the copy and
// the blanking of the bottom row. Each result beat is shown for one cycle with o_strobe
// high and cannot be held off.
module text_terminal_writer
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    input  logic        i_text_color_we,
    input  logic [7:0]  i_text_color,
    output logic        o_strobe,
    output logic [15:0] o_cell_data,
    output logic [4:0]  o_cursor_row_out,
    output logic [6:0]  o_cursor_col_out,
    output logic        o_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_cnt;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    t_byte         r_color;
    logic          r_strobe;
    logic          r_scrolled;
    logic          r_rd_ok;
    t_cell         r_cell_data;

    logic          accept;
    logic          is_put_draw;
    logic          at_last_col;
    logic          at_last_row;
    logic [AW-1:0] cursor_pos;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_cell         ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_cell         ram_rdata;
    logic [31:0]   row_ext;
    logic [31:0]   col_ext;

    assign accept      = start && (r_state == ST_IDLE);
    assign is_put_draw = (t_cmd'(i_cmd) == CMD_PUT) && (i_char_code != CH_NEWLINE)
                         && (i_char_code != CH_RETURN);
    assign at_last_col = (r_col == CW'(COLUMNS - 1));
    assign at_last_row = (r_row == RW'(ROWS - 1));
    assign cursor_pos  = AW'(32'(r_row) * COLUMNS + 32'(r_col));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = make_cell(CH_SPACE, r_color);
        ram_raddr = AW'(i_cell_index);
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = make_cell(CH_SPACE, RESET_COLOR);
            end
            ST_IDLE: begin
                ram_we    = accept && is_put_draw;
                ram_waddr = cursor_pos;
                ram_wdata = make_cell(i_char_code, r_color);
            end
            ST_READ: begin
            end
            ST_COPY: begin
                ram_raddr = AW'(32'(r_cnt) + COLUMNS);
                ram_we    = (r_cnt != '0);
                ram_waddr = r_cnt - AW'(1);
                ram_wdata = ram_rdata;
            end
            ST_BLANK: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    ttw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_color    <= RESET_COLOR;
            r_strobe   <= 1'b0;
            r_scrolled <= 1'b0;
            r_rd_ok    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_text_color_we) begin
                r_color <= i_text_color;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_cell_data <= '0;
                        r_scrolled  <= 1'b0;
                        if (t_cmd'(i_cmd) == CMD_READ) begin
                            r_rd_ok <= (32'(i_cell_index) < CELLS);
                            r_state <= ST_READ;
                        end else if (i_char_code == CH_RETURN) begin
                            r_col    <= '0;
                            r_strobe <= 1'b1;
                        end else if ((i_char_code == CH_NEWLINE) || at_last_col) begin
                            r_col <= '0;
                            if (at_last_row) begin
                                r_cnt   <= '0;
                                r_state <= ST_COPY;
                            end else begin
                                r_row    <= r_row + RW'(1);
                                r_strobe <= 1'b1;
                            end
                        end else begin
                            r_col    <= r_col + CW'(1);
                            r_strobe <= 1'b1;
                        end
                    end
                end
                ST_READ: begin
                    r_cell_data <= r_rd_ok ? ram_rdata : '0;
                    r_strobe    <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                ST_COPY: begin
                    if (r_cnt == AW'(CELLS - COLUMNS)) begin
                        r_state <= ST_BLANK;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                ST_BLANK: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(CELLS - 1)) begin
                        r_scrolled <= 1'b1;
                        r_strobe   <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign row_ext          = 32'(r_row);
    assign col_ext          = 32'(r_col);
    assign busy             = (r_state != ST_IDLE);
    assign o_strobe         = r_strobe;
    assign o_cell_data      = r_cell_data;
    assign o_cursor_row_out = row_ext[4:0];
    assign o_cursor_col_out = col_ext[6:0];
    assign o_scrolled       = r_scrolled;

    // Every accepted beat either reports at once or holds the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted beat neither reported nor busy");

    // A scroll always leaves the cursor at the start of the bottom row.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_scrolled) |-> (at_last_row && (r_col == '0)))
        else $error("scroll result with cursor off the bottom row start");

    // The screen is only written while idle when a put is being taken.
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == ST_IDLE)) |-> start)
        else $error("screen write while idle without a command");

    // Non-zero cell data only comes out of a read.
    a_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_cell_data != '0)) |-> $past(r_state == ST_READ))
        else $error("cell data reported for a put");

endmodule

// ===== rtl/ttw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
